### sv/mandelbrot_escape_counter_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape counter assertion macros
// Shared shorthands for the concurrent checks of the escape counter.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COUNTER_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mec_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter package
// Widths, register indexes, reset values and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

    // Data and product widths of the fixed-point datapath.
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ITER_W = 16;
    localparam int PIX_W  = 10;
    localparam int IDX_W  = 3;

    // Default number of fractional bits (Q4.28).
    localparam int FRAC_BITS_DEF = 28;

    // Escape radius squared, in whole units.
    localparam int ESC_RADIUS_SQ = 4;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic        [ITER_W-1:0] t_iter;
    typedef logic        [PIX_W-1:0]  t_pix;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_MAX_ITER  = 3'd0,
        REG_RE_ORIGIN = 3'd1,
        REG_IM_ORIGIN = 3'd2,
        REG_RE_STEP   = 3'd3,
        REG_IM_STEP   = 3'd4
    } t_reg_idx;

    // Register reset values.
    localparam t_iter MAX_ITER_RST  = 16'd256;
    localparam t_data RE_ORIGIN_RST = -32'sd536870912;
    localparam t_data IM_ORIGIN_RST = -32'sd268435456;
    localparam t_data RE_STEP_RST   = 32'sd786432;
    localparam t_data IM_STEP_RST   = 32'sd699051;

    // Saturation bounds of a data word, held at product width.
    localparam t_prod SAT_HI = t_prod'({1'b0, {(DATA_W-1){1'b1}}});
    localparam t_prod SAT_LO = -SAT_HI - t_prod'(1);

    // Clamp a wide signed value into the data word range.
    function automatic t_data sat_data(input t_prod v);
        t_data r;
        if (v > SAT_HI) begin
            r = t_data'(SAT_HI[DATA_W-1:0]);
        end else if (v < SAT_LO) begin
            r = t_data'(SAT_LO[DATA_W-1:0]);
        end else begin
            r = t_data'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/mec_mul.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter multiplier
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_mul
    import mec_pkg::*;
(
    input  wire logic  i_clk,
    input  wire t_data i_a,
    input  wire t_data i_b,
    output t_prod      o_prod
);

    t_prod r_prod;

    // Exact product, ready in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### sv/mandelbrot_escape_counter.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape counter
// Maps a pixel to a complex point and counts escape-time iterations.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low. The block then works
// on that pixel alone and returns one item, marked by o_done for a single
// cycle. The receiver cannot stall, so it must take the item in that cycle.
// One 32 by 32 multiplier is shared by every product: states S_CRE to S_CAPT
// map the pixel to c, and each iteration multiplies x*x, y*y and x*y in turn
// and then spends S_UPD on the escape test and the update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_counter_macros.svh"

module mandelbrot_escape_counter
    import mec_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Pixel input
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [PIX_W-1:0] i_col,
    input  wire logic [PIX_W-1:0] i_row,
    // Result output
    output logic                  o_done,
    output logic [ITER_W-1:0]     o_iterations,
    output logic                  o_inside_res,
    // Configuration write channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    // Escape limit on |z|^2 in the fixed-point scale.
    localparam t_prod ESC_LIMIT = t_prod'(ESC_RADIUS_SQ) <<< FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CRE  = 8'b0000_0010,
        S_CIM  = 8'b0000_0100,
        S_CAPT = 8'b0000_1000,
        S_XX   = 8'b0001_0000,
        S_YY   = 8'b0010_0000,
        S_XY   = 8'b0100_0000,
        S_UPD  = 8'b1000_0000
    } t_state;

    // Configuration registers
    t_iter  r_max_iter;
    t_data  r_re_origin;
    t_data  r_im_origin;
    t_data  r_re_step;
    t_data  r_im_step;

    // Sequencer and datapath registers
    t_state r_state, n_state;
    t_iter  r_iter, n_iter;
    logic   r_done, n_done;
    logic   r_inside, n_inside;
    t_pix   r_col, n_col;
    t_pix   r_row, n_row;
    t_data  r_x, n_x;
    t_data  r_y, n_y;
    t_data  r_c_re, n_c_re;
    t_data  r_c_im, n_c_im;
    t_prod  r_xx, n_xx;
    t_prod  r_yy, n_yy;

    // Multiplier operands and product
    t_data  w_mul_a;
    t_data  w_mul_b;
    t_prod  w_prod;

    // Update terms
    t_prod  w_mag;
    t_prod  w_xy2;
    t_prod  w_new_x;
    t_prod  w_new_y;

    mec_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= MAX_ITER_RST;
            r_re_origin <= RE_ORIGIN_RST;
            r_im_origin <= IM_ORIGIN_RST;
            r_re_step   <= RE_STEP_RST;
            r_im_step   <= IM_STEP_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_ITER:  r_max_iter  <= i_cfg_data[ITER_W-1:0];
                REG_RE_ORIGIN: r_re_origin <= t_data'(i_cfg_data);
                REG_IM_ORIGIN: r_im_origin <= t_data'(i_cfg_data);
                REG_RE_STEP:   r_re_step   <= t_data'(i_cfg_data);
                REG_IM_STEP:   r_im_step   <= t_data'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Escape test and next z, formed from the stored squares and cross product.
    assign w_mag   = r_xx + r_yy;
    assign w_xy2   = w_prod >>> (FRAC_BITS - 1);
    assign w_new_x = r_xx - r_yy + t_prod'(r_c_re);
    assign w_new_y = w_xy2 + t_prod'(r_c_im);

    // Sequencer: steers the shared multiplier and updates z.
    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_done   = 1'b0;
        n_inside = r_inside;
        n_col    = r_col;
        n_row    = r_row;
        n_x      = r_x;
        n_y      = r_y;
        n_c_re   = r_c_re;
        n_c_im   = r_c_im;
        n_xx     = r_xx;
        n_yy     = r_yy;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_col   = i_col;
                    n_row   = i_row;
                    n_iter  = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_state = S_CRE;
                end
            end
            S_CRE: begin
                w_mul_a = t_data'({{(DATA_W-PIX_W){1'b0}}, r_col});
                w_mul_b = r_re_step;
                n_state = S_CIM;
            end
            S_CIM: begin
                w_mul_a = t_data'({{(DATA_W-PIX_W){1'b0}}, r_row});
                w_mul_b = r_im_step;
                n_c_re  = sat_data(t_prod'(r_re_origin) + w_prod);
                n_state = S_CAPT;
            end
            S_CAPT: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
                n_c_im  = sat_data(t_prod'(r_im_origin) + w_prod);
                n_state = S_YY;
            end
            S_XX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
                n_state = S_YY;
            end
            S_YY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
                n_xx    = w_prod >>> FRAC_BITS;
                n_state = S_XY;
            end
            S_XY: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
                n_yy    = w_prod >>> FRAC_BITS;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_iter >= r_max_iter) begin
                    n_done   = 1'b1;
                    n_inside = 1'b1;
                    n_state  = S_IDLE;
                end else if (w_mag >= ESC_LIMIT) begin
                    n_done   = 1'b1;
                    n_inside = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    n_x     = sat_data(w_new_x);
                    n_y     = sat_data(w_new_y);
                    n_iter  = r_iter + t_iter'(1);
                    n_state = S_XX;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
        r_col    <= n_col;
        r_row    <= n_row;
        r_x      <= n_x;
        r_y      <= n_y;
        r_c_re   <= n_c_re;
        r_c_im   <= n_c_im;
        r_xx     <= n_xx;
        r_yy     <= n_yy;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_iterations = r_iter;
    assign o_inside_res = r_inside;

    // Checks on the sequencer.
    `MEC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item taken but not busy")
    `MEC_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `MEC_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe held")
    `MEC_ASSERT_IMP(a_iter_bound, i_clk, i_rst_n, busy, r_iter <= r_max_iter, "count past limit")
    `MEC_ASSERT_IMP(a_inside_cnt, i_clk, i_rst_n, o_done && o_inside_res, o_iterations == r_max_iter, "inside item below limit")

endmodule

`default_nettype wire
